// File: rtl/contiguous_segment_allocator_top_macros.svh
// Assertion macros shared by the segment allocator RTL.
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CSA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define CSA_ASSERT_IMPL(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/csa_pkg.sv
// Types and constants of the contiguous segment allocator.
package csa_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 32;
    localparam logic [31:0] TOTAL_SIZE_RST = 32'd1048576;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_COMPACT = 2'd2;
    localparam logic [1:0] OP_STATUS  = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_HOLE  = 2'd1;
    localparam logic [1:0] ST_NO_OWNER = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
        logic        used;
        logic [15:0] owner;
    } t_seg;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] base;
        logic [31:0] size;
        logic        in_use;
        logic [15:0] owner;
        logic        last;
    } t_res;

    function automatic t_res mk_res(logic [1:0] st, logic [31:0] base, logic [31:0] size,
                                    logic in_use, logic [15:0] owner, logic last);
        t_res r;
        r.status = st;
        r.base   = base;
        r.size   = size;
        r.in_use = in_use;
        r.owner  = owner;
        r.last   = last;
        return r;
    endfunction

endpackage

// File: rtl/contiguous_segment_allocator_top.sv
// Contiguous segment allocator: segment table in one synchronous memory.
//
//  channel   direction  handshake                 payload
//  command   in         start & !busy             i_opcode i_owner_id i_request_size i_fit_mode
//  result    out        o_result_strobe (1 cyc)   o_status_code o_seg_* o_last_result
//  config    in         i_cfg_valid & o_cfg_ready i_cfg_total_size
//
// Every command walks the table once through the memory read port, one
// entry per cycle. A request that splits a hole then moves the entries
// above the pick up by one and writes the split-off hole and the picked
// entry; an exact fit writes only the picked entry. A zero-size request answers at once.
// Status gives one result beat per entry during the walk.
// Reset (synchronous, active low) leaves one free segment [0, total_size);
// entry 0 reads from a fresh flag until first written, so no clearing pass.
// The receiver cannot stall; busy holds off new commands while one runs, and
// config is ready only while idle with start low, so a command wins a tie.
module contiguous_segment_allocator_top #(
    parameter int unsigned MAX_SEGMENTS = csa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_owner_id,
    input  logic [31:0] i_request_size,
    input  logic [1:0]  i_fit_mode,
    output logic        o_result_strobe,
    output logic [1:0]  o_status_code,
    output logic [31:0] o_seg_base,
    output logic [31:0] o_seg_size,
    output logic        o_seg_in_use,
    output logic [15:0] o_seg_owner,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_total_size
);

`include "contiguous_segment_allocator_top_macros.svh"

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHF, S_SPL, S_WPK} t_state;

    // segment table
    csa_pkg::t_seg mem [MAX_SEGMENTS];
    csa_pkg::t_seg r_rdata;

    t_state        r_state, n_state;
    logic [31:0]   r_total, n_total;
    logic [CW-1:0] r_count, n_count;
    logic          r_fresh, n_fresh;
    logic [1:0]    r_op, n_op;
    logic [15:0]   r_owner, n_owner;
    logic [31:0]   r_size, n_size;
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_rd, n_rd;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_di, n_di;
    logic          r_rd0, n_rd0;
    logic          r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;
    csa_pkg::t_seg r_pe, n_pe;
    logic [CW-1:0] r_n, n_n;
    logic [31:0]   r_addr, n_addr;
    logic [IW-1:0] r_src, n_src;
    logic          r_sv, n_sv;
    logic [IW-1:0] r_si, n_si;
    logic          r_strobe, n_strobe;
    csa_pkg::t_res r_res, n_res;

    logic          rd_en;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    csa_pkg::t_seg wdata;
    csa_pkg::t_seg e;
    logic          fit;
    logic          cfg_fire;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // entry 0 holds the reset segment until it is first written
    always_comb begin
        if (r_rd0 && r_fresh) begin
            e = '{start: 32'd0, len: r_total, used: 1'b0, owner: 16'd0};
        end else begin
            e = r_rdata;
        end
    end

    assign fit = !e.used && (e.len >= r_size);

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_count  = r_count;
        n_fresh  = r_fresh;
        n_op     = r_op;
        n_owner  = r_owner;
        n_size   = r_size;
        n_mode   = r_mode;
        n_rd     = r_rd;
        n_dv     = 1'b0;
        n_di     = r_di;
        n_rd0    = 1'b0;
        n_found  = r_found;
        n_pick   = r_pick;
        n_pe     = r_pe;
        n_n      = r_n;
        n_addr   = r_addr;
        n_src    = r_src;
        n_sv     = 1'b0;
        n_si     = r_si;
        n_strobe = 1'b0;
        n_res    = r_res;
        rd_en    = 1'b0;
        raddr    = r_rd[IW-1:0];
        we       = 1'b0;
        waddr    = '0;
        wdata    = e;

        case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    n_total = i_cfg_total_size;
                    n_count = CW'(1);
                    n_fresh = 1'b1;
                end else if (start) begin
                    n_op    = i_opcode;
                    n_owner = i_owner_id;
                    n_size  = i_request_size;
                    n_mode  = i_fit_mode;
                    n_rd    = '0;
                    n_found = 1'b0;
                    n_n     = '0;
                    n_addr  = '0;
                    if (i_opcode == csa_pkg::OP_REQUEST && i_request_size == 32'd0) begin
                        n_strobe = 1'b1;
                        n_res = csa_pkg::mk_res(csa_pkg::ST_FULL, 32'd0, 32'd0, 1'b0,
                                                16'd0, 1'b1);
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue the next read while the previous beat is evaluated
                if (r_rd < r_count) begin
                    rd_en = 1'b1;
                    n_rd  = r_rd + 1'b1;
                    n_dv  = 1'b1;
                    n_di  = r_rd[IW-1:0];
                    n_rd0 = (r_rd == '0);
                end
                if (r_dv) begin
                    case (r_op)
                        csa_pkg::OP_REQUEST: begin
                            if (fit && (!r_found
                                    || (r_mode == csa_pkg::FIT_BEST && e.len < r_pe.len)
                                    || (r_mode == csa_pkg::FIT_WORST && e.len > r_pe.len)))
                            begin
                                n_found = 1'b1;
                                n_pick  = r_di;
                                n_pe    = e;
                            end
                        end
                        csa_pkg::OP_RELEASE: begin
                            if (!r_found && e.used && e.owner == r_owner) begin
                                n_found = 1'b1;
                                n_pick  = r_di;
                                n_pe    = e;
                            end
                        end
                        csa_pkg::OP_COMPACT: begin
                            // pack used entries downward; write index never passes reads
                            if (e.used) begin
                                we     = 1'b1;
                                waddr  = r_n[IW-1:0];
                                wdata  = '{start: r_addr, len: e.len, used: 1'b1,
                                           owner: e.owner};
                                n_addr = r_addr + e.len;
                                n_n    = r_n + 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res = csa_pkg::mk_res(csa_pkg::ST_OK, e.start, e.len, e.used,
                                                    e.used ? e.owner : 16'd0,
                                                    CW'(r_di) == r_count - 1'b1);
                        end
                    endcase
                end else if (r_rd >= r_count) begin
                    // walk finished
                    n_state = S_IDLE;
                    case (r_op)
                        csa_pkg::OP_REQUEST: begin
                            if (!r_found) begin
                                n_strobe = 1'b1;
                                n_res = csa_pkg::mk_res(csa_pkg::ST_NO_HOLE, 32'd0, 32'd0,
                                                        1'b0, 16'd0, 1'b1);
                            end else if (r_pe.len == r_size) begin
                                n_state = S_WPK;
                            end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                                n_strobe = 1'b1;
                                n_res = csa_pkg::mk_res(csa_pkg::ST_FULL, 32'd0, 32'd0,
                                                        1'b0, 16'd0, 1'b1);
                            end else begin
                                n_state = S_SHF;
                                n_src   = IW'(r_count - 1'b1);
                            end
                        end
                        csa_pkg::OP_RELEASE: begin
                            n_strobe = 1'b1;
                            if (r_found) begin
                                we    = 1'b1;
                                waddr = r_pick;
                                wdata = '{start: r_pe.start, len: r_pe.len, used: 1'b0,
                                          owner: r_pe.owner};
                                n_res = csa_pkg::mk_res(csa_pkg::ST_OK, r_pe.start,
                                                        r_pe.len, 1'b0, r_owner, 1'b1);
                            end else begin
                                n_res = csa_pkg::mk_res(csa_pkg::ST_NO_OWNER, 32'd0,
                                                        32'd0, 1'b0, 16'd0, 1'b1);
                            end
                        end
                        csa_pkg::OP_COMPACT: begin
                            n_strobe = 1'b1;
                            if (r_n == '0 || r_addr < r_total) begin
                                we      = 1'b1;
                                waddr   = r_n[IW-1:0];
                                wdata   = '{start: r_addr, len: r_total - r_addr,
                                            used: 1'b0, owner: 16'd0};
                                n_count = r_n + 1'b1;
                                n_res   = csa_pkg::mk_res(csa_pkg::ST_OK, r_addr,
                                                          r_total - r_addr, 1'b0, 16'd0,
                                                          1'b1);
                            end else begin
                                n_count = r_n;
                                n_res   = csa_pkg::mk_res(csa_pkg::ST_OK, r_addr, 32'd0,
                                                          1'b0, 16'd0, 1'b1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SHF: begin
                // move entries above the pick up by one, top first
                if (r_sv) begin
                    we    = 1'b1;
                    waddr = r_si + 1'b1;
                    wdata = e;
                end
                if (r_src > r_pick) begin
                    rd_en = 1'b1;
                    raddr = r_src;
                    n_sv  = 1'b1;
                    n_si  = r_src;
                    n_src = r_src - 1'b1;
                end else if (!r_sv) begin
                    n_state = S_SPL;
                end
            end

            S_SPL: begin
                we      = 1'b1;
                waddr   = r_pick + 1'b1;
                wdata   = '{start: r_pe.start + r_size, len: r_pe.len - r_size,
                            used: 1'b0, owner: 16'd0};
                n_state = S_WPK;
            end

            S_WPK: begin
                we       = 1'b1;
                waddr    = r_pick;
                wdata    = '{start: r_pe.start, len: r_size, used: 1'b1, owner: r_owner};
                n_strobe = 1'b1;
                n_res    = csa_pkg::mk_res(csa_pkg::ST_OK, r_pe.start, r_size, 1'b1,
                                           r_owner, 1'b1);
                if (r_pe.len != r_size) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (we && waddr == '0) begin
            n_fresh = 1'b0;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= csa_pkg::TOTAL_SIZE_RST;
            r_count  <= CW'(1);
            r_fresh  <= 1'b1;
            r_dv     <= 1'b0;
            r_rd0    <= 1'b0;
            r_sv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_count  <= n_count;
            r_fresh  <= n_fresh;
            r_dv     <= n_dv;
            r_rd0    <= n_rd0;
            r_sv     <= n_sv;
            r_strobe <= n_strobe;
        end
        r_op    <= n_op;
        r_owner <= n_owner;
        r_size  <= n_size;
        r_mode  <= n_mode;
        r_rd    <= n_rd;
        r_di    <= n_di;
        r_found <= n_found;
        r_pick  <= n_pick;
        r_pe    <= n_pe;
        r_n     <= n_n;
        r_addr  <= n_addr;
        r_src   <= n_src;
        r_si    <= n_si;
        r_res   <= n_res;
    end

    assign o_result_strobe = r_strobe;
    assign o_status_code   = r_res.status;
    assign o_seg_base      = r_res.base;
    assign o_seg_size      = r_res.size;
    assign o_seg_in_use    = r_res.in_use;
    assign o_seg_owner     = r_res.owner;
    assign o_last_result   = r_res.last;

    `CSA_ASSERT_ALWAYS(a_count_range, r_count != '0 && r_count <= CW'(MAX_SEGMENTS), "segment count out of range")
    `CSA_ASSERT_IMPL(a_err_is_last, r_strobe && r_res.status != csa_pkg::ST_OK, r_res.last, "failed result not last")
    `CSA_ASSERT_IMPL(a_split_room, r_state == S_SPL, r_count < CW'(MAX_SEGMENTS), "split with full table")
    `CSA_ASSERT_IMPL(a_shift_above, r_state == S_SHF && r_sv, r_si > r_pick, "shift below picked entry")

endmodule
